FILE: hw/rtl/stick_command_arm_encoder_core_macros.svh
// Assertion helpers for the RTL file that checks itself.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef STICK_COMMAND_ARM_ENCODER_CORE_MACROS_SVH
`define STICK_COMMAND_ARM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication.
`define SCE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sce_pkg.sv
package sce_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int CFG_W        = 16;
    localparam int IDX_W        = 3;

    localparam int DEADBAND     = 40;
    localparam int SPAN         = 1800;
    localparam int THR_FLOOR    = 120;
    localparam int SEND_PERIOD  = 20;
    // 5 * 3641, where 3641 / 65536 rounds 1/18 up; exact for products below 32768
    localparam int SCALE_RECIP  = 18205;
    localparam int SCALE_SHIFT  = 16;

    localparam logic [11:0] CENTER_RST    = 12'd2048;
    localparam logic [11:0] GEST_THR_RST  = 12'd900;
    localparam logic [15:0] HOLD_MS_RST   = 16'd3000;
    localparam logic [15:0] DEBOUNCE_RST  = 16'd250;
    localparam logic [15:0] GRACE_RST     = 16'd300;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_THROTTLE = 3'd0,
        REG_CENTER_YAW      = 3'd1,
        REG_CENTER_PITCH    = 3'd2,
        REG_CENTER_ROLL     = 3'd3,
        REG_GESTURE_THR     = 3'd4,
        REG_GESTURE_HOLD    = 3'd5,
        REG_DEBOUNCE        = 3'd6,
        REG_GRACE           = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [11:0] center_throttle;
        logic [11:0] center_yaw;
        logic [11:0] center_pitch;
        logic [11:0] center_roll;
        logic [11:0] gesture_threshold;
        logic [15:0] gesture_hold_ms;
        logic [15:0] debounce_ms;
        logic [15:0] grace_ms;
    } t_cfg;

    typedef struct packed {
        logic armed;
        logic calibrate;
        logic thr_block;
        logic send;
    } t_ctl_res;

    function automatic int diff_width(input int adc_bits);
        return ((adc_bits > 12) ? adc_bits : 12) + 2;
    endfunction

endpackage

FILE: hw/rtl/stick_command_arm_encoder_core.sv
// Stick command and arm encoder.
// Input channel (i_in_valid / o_in_stall) carries one control-loop sample: a
// millisecond time stamp, two active-low stick clicks and four ADC readings.
// Output channel (o_out_valid / i_out_stall) returns one command transaction
// per sample: armed flag, calibrate flag, throttle/yaw/pitch/roll commands and
// the 20 ms send strobe. Centers, gesture threshold and the hold, debounce and
// grace times are set over the write port (i_cfg_we, i_cfg_idx, i_cfg_data);
// the user must set them only while the block is idle; the block does not enforce it.
// A sample accepted into the input register moves into the result register
// when that register is free and shows on the outputs from there; the input
// register and the result register bound a single combinational pass
// (subtract, clamp, one constant multiply, 32-bit time compares).
// Throughput: one sample per cycle, sustained while the receiver does not stall.
// Reset clears the arm, gesture, debounce and send state and loads the
// default register values; no clearing pass, the block accepts at once.
// When the receiver stalls, the result register holds its transaction and one
// more sample may wait in the input register; o_in_stall rises only when
// both are full.
module stick_command_arm_encoder_core
    import sce_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // sample channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [31:0]         i_now_ms,
    input  logic                i_left_click,
    input  logic                i_right_click,
    input  logic [ADC_BITS-1:0] i_raw_throttle,
    input  logic [ADC_BITS-1:0] i_raw_yaw,
    input  logic [ADC_BITS-1:0] i_raw_pitch,
    input  logic [ADC_BITS-1:0] i_raw_roll,
    // command channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_armed_flag,
    output logic                o_cal_flag,
    output logic [9:0]          o_throttle_cmd,
    output logic signed [9:0]   o_yaw_cmd,
    output logic signed [9:0]   o_pitch_cmd,
    output logic signed [9:0]   o_roll_cmd,
    output logic                o_send_now
);

`include "stick_command_arm_encoder_core_macros.svh"

    localparam int DW = diff_width(ADC_BITS);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_throttle   <= CENTER_RST;
            r_cfg.center_yaw        <= CENTER_RST;
            r_cfg.center_pitch      <= CENTER_RST;
            r_cfg.center_roll       <= CENTER_RST;
            r_cfg.gesture_threshold <= GEST_THR_RST;
            r_cfg.gesture_hold_ms   <= HOLD_MS_RST;
            r_cfg.debounce_ms       <= DEBOUNCE_RST;
            r_cfg.grace_ms          <= GRACE_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_THROTTLE: r_cfg.center_throttle   <= i_cfg_data[11:0];
                REG_CENTER_YAW:      r_cfg.center_yaw        <= i_cfg_data[11:0];
                REG_CENTER_PITCH:    r_cfg.center_pitch      <= i_cfg_data[11:0];
                REG_CENTER_ROLL:     r_cfg.center_roll       <= i_cfg_data[11:0];
                REG_GESTURE_THR:     r_cfg.gesture_threshold <= i_cfg_data[11:0];
                REG_GESTURE_HOLD:    r_cfg.gesture_hold_ms   <= i_cfg_data[15:0];
                REG_DEBOUNCE:        r_cfg.debounce_ms       <= i_cfg_data[15:0];
                REG_GRACE:           r_cfg.grace_ms          <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // handshake: the result register frees when it is empty or being taken
    logic r_s1_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_adv;
    logic w_accept;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    // input register
    logic [31:0]         r_s1_now;
    logic                r_s1_left;
    logic                r_s1_right;
    logic [ADC_BITS-1:0] r_s1_thr;
    logic [ADC_BITS-1:0] r_s1_yaw;
    logic [ADC_BITS-1:0] r_s1_pit;
    logic [ADC_BITS-1:0] r_s1_rol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_now   <= i_now_ms;
            r_s1_left  <= i_left_click;
            r_s1_right <= i_right_click;
            r_s1_thr   <= i_raw_throttle;
            r_s1_yaw   <= i_raw_yaw;
            r_s1_pit   <= i_raw_pitch;
            r_s1_rol   <= i_raw_roll;
        end
    end

    // single pass: axis mapping, throttle mapping, arm/gesture/send control
    logic signed [DW-1:0] w_d_thr, w_d_yaw, w_d_pit, w_d_rol;
    logic [9:0]           w_thr_cmd;
    logic signed [9:0]    w_yaw_cmd, w_pit_cmd, w_rol_cmd;
    t_ctl_res             w_ctl;

    sce_throttle #(.ADC_BITS(ADC_BITS)) u_throttle (
        .i_raw    (r_s1_thr),
        .i_center (r_cfg.center_throttle),
        .i_block  (w_ctl.thr_block),
        .o_diff   (w_d_thr),
        .o_cmd    (w_thr_cmd)
    );

    sce_axis #(.ADC_BITS(ADC_BITS)) u_yaw (
        .i_raw    (r_s1_yaw),
        .i_center (r_cfg.center_yaw),
        .i_flip   (1'b0),
        .o_diff   (w_d_yaw),
        .o_cmd    (w_yaw_cmd)
    );

    // pitch is inverted
    sce_axis #(.ADC_BITS(ADC_BITS)) u_pitch (
        .i_raw    (r_s1_pit),
        .i_center (r_cfg.center_pitch),
        .i_flip   (1'b1),
        .o_diff   (w_d_pit),
        .o_cmd    (w_pit_cmd)
    );

    sce_axis #(.ADC_BITS(ADC_BITS)) u_roll (
        .i_raw    (r_s1_rol),
        .i_center (r_cfg.center_roll),
        .i_flip   (1'b0),
        .o_diff   (w_d_rol),
        .o_cmd    (w_rol_cmd)
    );

    // state advances only when the sample moves into the result register
    sce_ctl #(.ADC_BITS(ADC_BITS)) u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_cfg         (r_cfg),
        .i_now_ms      (r_s1_now),
        .i_left_click  (r_s1_left),
        .i_right_click (r_s1_right),
        .i_d_thr       (w_d_thr),
        .i_d_yaw       (w_d_yaw),
        .i_d_pit       (w_d_pit),
        .i_d_rol       (w_d_rol),
        .o_res         (w_ctl)
    );

    // result register
    logic              r_out_armed;
    logic              r_out_cal;
    logic [9:0]        r_out_thr;
    logic signed [9:0] r_out_yaw;
    logic signed [9:0] r_out_pit;
    logic signed [9:0] r_out_rol;
    logic              r_out_send;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_armed <= w_ctl.armed;
            r_out_cal   <= w_ctl.calibrate;
            r_out_thr   <= w_thr_cmd;
            r_out_yaw   <= w_yaw_cmd;
            r_out_pit   <= w_pit_cmd;
            r_out_rol   <= w_rol_cmd;
            r_out_send  <= w_ctl.send;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_armed_flag   = r_out_armed;
    assign o_cal_flag     = r_out_cal;
    assign o_throttle_cmd = r_out_thr;
    assign o_yaw_cmd      = r_out_yaw;
    assign o_pitch_cmd    = r_out_pit;
    assign o_roll_cmd     = r_out_rol;
    assign o_send_now     = r_out_send;

    `SCE_ASSERT_IMPL(a_thr_zero_disarmed, r_out_valid && !r_out_armed, r_out_thr == '0, "throttle nonzero while disarmed")
    `SCE_ASSERT_IMPL(a_cal_only_disarmed, r_out_valid && r_out_cal, !r_out_armed, "calibrate raised while armed")
    `SCE_ASSERT_NEXT(a_adv_lands, w_adv, r_out_valid, "advanced sample missing from result register")
    `SCE_ASSERT_NEXT(a_stall_keeps, r_out_valid && i_out_stall, r_out_valid, "stalled result dropped")

endmodule

FILE: hw/rtl/sce_axis.sv
module sce_axis
    import sce_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0]                  i_raw,
    input  logic [11:0]                          i_center,
    input  logic                                 i_flip,
    output logic signed [diff_width(ADC_BITS)-1:0] o_diff,
    output logic signed [9:0]                    o_cmd
);

    localparam int DW = diff_width(ADC_BITS);

    logic signed [DW-1:0] w_d;
    logic                 w_neg;
    logic [DW-1:0]        w_abs;
    logic [10:0]          w_mag;
    logic [25:0]          w_prod;
    logic [9:0]           w_q;

    assign w_d    = $signed(DW'(i_raw)) - $signed(DW'(i_center));
    assign w_neg  = w_d[DW-1];
    assign w_abs  = w_neg ? DW'(-w_d) : DW'(w_d);
    assign o_diff = w_d;

    // Deadband, then clamp to the span
    always_comb begin
        if (w_abs < DW'(DEADBAND)) begin
            w_mag = '0;
        end else if (w_abs > DW'(SPAN)) begin
            w_mag = 11'(SPAN);
        end else begin
            w_mag = w_abs[10:0];
        end
    end

    assign w_prod = 26'(w_mag) * 26'(SCALE_RECIP);
    assign w_q    = w_prod[SCALE_SHIFT +: 10];
    assign o_cmd  = (w_neg ^ i_flip) ? $signed(-w_q) : $signed(w_q);

endmodule

FILE: hw/rtl/sce_throttle.sv
module sce_throttle
    import sce_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0]                  i_raw,
    input  logic [11:0]                          i_center,
    input  logic                                 i_block,
    output logic signed [diff_width(ADC_BITS)-1:0] o_diff,
    output logic [9:0]                           o_cmd
);

    localparam int DW = diff_width(ADC_BITS);

    logic signed [DW-1:0] w_d;
    logic signed [DW-1:0] w_c;
    logic [11:0]          w_x;
    logic [26:0]          w_prod;
    logic [10:0]          w_q;

    assign w_d    = $signed(DW'(i_raw)) - $signed(DW'(i_center));
    assign o_diff = w_d;

    always_comb begin
        if (w_d > $signed(DW'(SPAN))) begin
            w_c = $signed(DW'(SPAN));
        end else if (w_d < -$signed(DW'(SPAN))) begin
            w_c = -$signed(DW'(SPAN));
        end else begin
            w_c = w_d;
        end
    end

    // Offset into 0..3600, scale by 1000/3600
    assign w_x    = 12'(w_c + $signed(DW'(SPAN)));
    assign w_prod = 27'(w_x) * 27'(SCALE_RECIP);
    assign w_q    = w_prod[SCALE_SHIFT +: 11];

    always_comb begin
        if (i_block || (w_d < -$signed(DW'(THR_FLOOR)))) begin
            o_cmd = '0;
        end else begin
            o_cmd = w_q[9:0];
        end
    end

endmodule

FILE: hw/rtl/sce_ctl.sv
module sce_ctl
    import sce_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  t_cfg                                 i_cfg,
    input  logic [31:0]                          i_now_ms,
    input  logic                                 i_left_click,
    input  logic                                 i_right_click,
    input  logic signed [diff_width(ADC_BITS)-1:0] i_d_thr,
    input  logic signed [diff_width(ADC_BITS)-1:0] i_d_yaw,
    input  logic signed [diff_width(ADC_BITS)-1:0] i_d_pit,
    input  logic signed [diff_width(ADC_BITS)-1:0] i_d_rol,
    output t_ctl_res                             o_res
);

    localparam int DW = diff_width(ADC_BITS);

    logic        r_armed, n_armed;
    logic        r_prev_l, r_prev_r;
    logic [31:0] r_last_tog, n_last_tog;
    logic [31:0] r_grace, n_grace;
    logic [31:0] r_hold_start, n_hold_start;
    logic        r_fired, n_fired;
    logic [31:0] r_last_send, n_last_send;

    logic                 w_edge;
    logic                 w_tog;
    logic signed [DW-1:0] w_th;
    logic                 w_gesture;
    logic [31:0]          w_hs_eff;
    logic                 w_fired_eff;
    logic                 w_send;

    assign w_edge = (r_prev_l & ~i_left_click) | (r_prev_r & ~i_right_click);
    assign w_tog  = w_edge && ((i_now_ms - r_last_tog) > 32'(i_cfg.debounce_ms));
    assign w_th   = $signed(DW'(i_cfg.gesture_threshold));

    always_comb begin
        n_armed     = r_armed;
        n_last_tog  = r_last_tog;
        n_grace     = r_grace;
        if (w_tog) begin
            n_armed    = ~r_armed;
            n_last_tog = i_now_ms;
            n_grace    = ~r_armed ? (i_now_ms + 32'(i_cfg.grace_ms)) : '0;
        end

        w_gesture = !n_armed && (i_d_thr < -w_th) && (i_d_yaw > w_th) &&
                    (i_d_pit < -w_th) && (i_d_rol < -w_th);

        // A zero start stamp means not holding: restart the hold here
        w_hs_eff    = (r_hold_start == '0) ? i_now_ms : r_hold_start;
        w_fired_eff = (r_hold_start == '0) ? 1'b0 : r_fired;
        if (w_gesture) begin
            n_hold_start = w_hs_eff;
            n_fired      = w_fired_eff ||
                           ((i_now_ms - w_hs_eff) >= 32'(i_cfg.gesture_hold_ms));
        end else begin
            n_hold_start = '0;
            n_fired      = 1'b0;
        end

        w_send      = (i_now_ms - r_last_send) >= 32'(SEND_PERIOD);
        n_last_send = w_send ? i_now_ms : r_last_send;

        o_res.armed     = n_armed;
        o_res.calibrate = w_gesture && n_fired;
        o_res.thr_block = !n_armed || ((n_grace != '0) && (i_now_ms < n_grace));
        o_res.send      = w_send;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_prev_l     <= 1'b1;
            r_prev_r     <= 1'b1;
            r_last_tog   <= '0;
            r_grace      <= '0;
            r_hold_start <= '0;
            r_fired      <= 1'b0;
            r_last_send  <= '0;
        end else if (i_adv) begin
            r_armed      <= n_armed;
            r_prev_l     <= i_left_click;
            r_prev_r     <= i_right_click;
            r_last_tog   <= n_last_tog;
            r_grace      <= n_grace;
            r_hold_start <= n_hold_start;
            r_fired      <= n_fired;
            r_last_send  <= n_last_send;
        end
    end

endmodule

FILE: sim/tb.sv
module tb
    import sce_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Command scale factors and run bounds.
    localparam int AXIS_FULL       = 500;
    localparam int THR_FULL        = 1000;
    localparam int ADC_MAX         = 4095;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 300000;

    // One command transaction as seen on the output channel.
    typedef struct packed {
        logic       armed;
        logic       cal;
        logic [9:0] thr;
        logic [9:0] yaw;
        logic [9:0] pitch;
        logic [9:0] roll;
        logic       send;
    } t_cmd;

    typedef enum int {MODE_NOISE, MODE_FLIGHT, MODE_GESTURE} t_stim_mode;
    typedef enum int {SET_LOW, SET_HIGH, SET_DEFAULT, SET_RANDOM} t_set_kind;

    // ------------------------------------------------------------------
    // Command predictor: its own copy of the registers and the arm,
    // gesture, debounce and send state, plus the queue of commands that
    // are owed by the block.
    // ------------------------------------------------------------------
    class command_predictor;
        logic [11:0] ctr_thr, ctr_yaw, ctr_pit, ctr_rol, gest_th;
        logic [15:0] hold_ms, deb_ms, grace_ms;
        bit          armed, prev_l, prev_r, hold_fired;
        bit   [31:0] last_toggle, grace_until, hold_start, last_send;
        t_cmd        owed_cmds[$];
        int          errors;

        function new();
            ctr_thr = CENTER_RST;
            ctr_yaw = CENTER_RST;
            ctr_pit = CENTER_RST;
            ctr_rol = CENTER_RST;
            gest_th = GEST_THR_RST;
            hold_ms = HOLD_MS_RST;
            deb_ms = DEBOUNCE_RST;
            grace_ms = GRACE_RST;
            armed = 1'b0;
            prev_l = 1'b1;
            prev_r = 1'b1;
            hold_fired = 1'b0;
            last_toggle = '0;
            grace_until = '0;
            hold_start = '0;
            last_send = '0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] data);
            case (idx)
                REG_CENTER_THROTTLE: ctr_thr = data[11:0];
                REG_CENTER_YAW:      ctr_yaw = data[11:0];
                REG_CENTER_PITCH:    ctr_pit = data[11:0];
                REG_CENTER_ROLL:     ctr_rol = data[11:0];
                REG_GESTURE_THR:     gest_th = data[11:0];
                REG_GESTURE_HOLD:    hold_ms = data;
                REG_DEBOUNCE:        deb_ms = data;
                REG_GRACE:           grace_ms = data;
                default: ;
            endcase
        endfunction

        function int clamp_span(int v);
            if (v > SPAN) return SPAN;
            if (v < -SPAN) return -SPAN;
            return v;
        endfunction

        function int axis_of(int raw, int ctr, bit flip);
            int v;
            int o;
            v = raw - ctr;
            if (v > -DEADBAND && v < DEADBAND) v = 0;
            o = clamp_span(v) * AXIS_FULL / SPAN;
            if (flip) o = -o;
            return o;
        endfunction

        function int pending();
            return owed_cmds.size();
        endfunction

        // Advance the state by one accepted sample and queue its command.
        function void note_sample(bit [31:0] now, bit l, bit r,
                                  int a_thr, int a_yaw, int a_pit, int a_rol);
            bit   click_fall;
            bit   gesture;
            int   th, c_thr, c_yaw, c_pit, c_rol, thr;
            t_cmd cmd;
            th = gest_th;
            c_thr = ctr_thr;
            c_yaw = ctr_yaw;
            c_pit = ctr_pit;
            c_rol = ctr_rol;
            cmd = '0;

            click_fall = (prev_l && !l) || (prev_r && !r);
            if (click_fall && (now - last_toggle) > {16'd0, deb_ms}) begin
                armed = !armed;
                last_toggle = now;
                grace_until = armed ? now + {16'd0, grace_ms} : 32'd0;
            end
            prev_l = l;
            prev_r = r;

            gesture = !armed && (a_thr < c_thr - th) && (a_yaw > c_yaw + th) &&
                      (a_pit < c_pit - th) && (a_rol < c_rol - th);
            if (gesture) begin
                // a zero stamp means not holding, so a hold begun at 0 restarts
                if (hold_start == 0) begin
                    hold_start = now;
                    hold_fired = 1'b0;
                end
                if (!hold_fired && (now - hold_start) >= {16'd0, hold_ms})
                    hold_fired = 1'b1;
                cmd.cal = hold_fired;
            end else begin
                hold_start = '0;
                hold_fired = 1'b0;
            end

            thr = (clamp_span(a_thr - c_thr) + SPAN) * THR_FULL / (2 * SPAN);
            if (a_thr < c_thr - THR_FLOOR) thr = 0;
            if (!armed || (grace_until != 0 && now < grace_until)) thr = 0;

            if ((now - last_send) >= SEND_PERIOD) begin
                last_send = now;
                cmd.send = 1'b1;
            end

            cmd.armed = armed;
            cmd.thr = thr[9:0];
            cmd.yaw = 10'(axis_of(a_yaw, c_yaw, 1'b0));
            cmd.pitch = 10'(axis_of(a_pit, c_pit, 1'b1));
            cmd.roll = 10'(axis_of(a_rol, c_rol, 1'b0));
            owed_cmds.push_back(cmd);
        endfunction

        function void compare_field(string name, logic [9:0] e, logic [9:0] a, bit sgn);
            if (a !== e) begin
                errors++;
                if (sgn)
                    $display("%0t: %s expected %0d, got %0d", $time, name,
                             $signed(e), $signed(a));
                else
                    $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
            end
        endfunction

        // Compare one accepted command transaction with the oldest owed one.
        function void check_command(t_cmd got);
            t_cmd want;
            if (owed_cmds.size() == 0) begin
                errors++;
                $display("%0t: command transaction with no sample outstanding", $time);
                return;
            end
            want = owed_cmds.pop_front();
            compare_field("armed_flag", 10'(want.armed), 10'(got.armed), 1'b0);
            compare_field("cal_flag", 10'(want.cal), 10'(got.cal), 1'b0);
            compare_field("throttle_cmd", want.thr, got.thr, 1'b0);
            compare_field("yaw_cmd", want.yaw, got.yaw, 1'b1);
            compare_field("pitch_cmd", want.pitch, got.pitch, 1'b1);
            compare_field("roll_cmd", want.roll, got.roll, 1'b1);
            compare_field("send_now", 10'(want.send), 10'(got.send), 1'b0);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [31:0]         i_now_ms;
    logic                i_left_click;
    logic                i_right_click;
    logic [11:0]         i_raw_throttle;
    logic [11:0]         i_raw_yaw;
    logic [11:0]         i_raw_pitch;
    logic [11:0]         i_raw_roll;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_armed_flag;
    logic                o_cal_flag;
    logic [9:0]          o_throttle_cmd;
    logic signed [9:0]   o_yaw_cmd;
    logic signed [9:0]   o_pitch_cmd;
    logic signed [9:0]   o_roll_cmd;
    logic                o_send_now;

    stick_command_arm_encoder_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_now_ms          (i_now_ms),
        .i_left_click      (i_left_click),
        .i_right_click     (i_right_click),
        .i_raw_throttle    (i_raw_throttle),
        .i_raw_yaw         (i_raw_yaw),
        .i_raw_pitch       (i_raw_pitch),
        .i_raw_roll        (i_raw_roll),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_armed_flag      (o_armed_flag),
        .o_cal_flag        (o_cal_flag),
        .o_throttle_cmd    (o_throttle_cmd),
        .o_yaw_cmd         (o_yaw_cmd),
        .o_pitch_cmd       (o_pitch_cmd),
        .o_roll_cmd        (o_roll_cmd),
        .o_send_now        (o_send_now)
    );

    command_predictor sb;

    // Next sample to present, and the stimulus bookkeeping around it.
    bit   [31:0] s_now;
    bit          s_l, s_r;
    int          s_thr, s_yaw, s_pit, s_rol;
    int          l_hold, r_hold;
    int          burst_left;
    logic [15:0] cfg_vals [8];

    int          cycle_count;
    int          stall_mode;
    int          stall_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted command transaction, run the receiver
    // stall pattern and the timeout.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stick_command_arm_encoder_core test failed");
            $finish;
        end else begin
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_command({o_armed_flag, o_cal_flag, o_throttle_cmd,
                                  o_yaw_cmd, o_pitch_cmd, o_roll_cmd, o_send_now});
            // pick a new stall style when the current one runs out
            if (stall_left <= 0) begin
                stall_mode = $urandom_range(3, 0);
                stall_left = $urandom_range(300, 50);
            end
            stall_left--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(3, 0) == 0);
                2: i_out_stall <= ($urandom_range(3, 0) != 0);
                default: i_out_stall <= ((cycle_count % 8) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // Present the current sample, hold it until accepted, then pace the
    // sender in bursts with random gaps.
    task automatic drive_sample();
        int gap;
        i_in_valid <= 1'b1;
        i_now_ms <= s_now;
        i_left_click <= s_l;
        i_right_click <= s_r;
        i_raw_throttle <= s_thr[11:0];
        i_raw_yaw <= s_yaw[11:0];
        i_raw_pitch <= s_pit[11:0];
        i_raw_roll <= s_rol[11:0];
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s_now, s_l, s_r, s_thr, s_yaw, s_pit, s_rol);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            burst_left = $urandom_range(30, 1);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_item(bit [31:0] now, bit l, bit r, int thr, int yaw, int pit, int rol);
        s_now = now;
        s_l = l;
        s_r = r;
        s_thr = thr;
        s_yaw = yaw;
        s_pit = pit;
        s_rol = rol;
        drive_sample();
    endtask

    // Drop valid, wait for every owed command, then let the pipe settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all eight registers back to back, holding the enable high.
    task automatic load_settings();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= IDX_W'(i);
            i_cfg_data <= cfg_vals[i];
            @(posedge i_clk);
            sb.set_reg(t_reg_idx'(i), cfg_vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Fill the register image; some 12-bit registers get junk in the top nibble.
    task automatic pick_settings(t_set_kind kind);
        logic [3:0] junk;
        junk = 4'($urandom);
        case (kind)
            SET_LOW: begin
                cfg_vals[REG_CENTER_THROTTLE] = {junk, 12'd0};
                cfg_vals[REG_CENTER_YAW]      = 16'd0;
                cfg_vals[REG_CENTER_PITCH]    = 16'd0;
                cfg_vals[REG_CENTER_ROLL]     = 16'd0;
                cfg_vals[REG_GESTURE_THR]     = 16'd0;
                cfg_vals[REG_GESTURE_HOLD]    = 16'd0;
                cfg_vals[REG_DEBOUNCE]        = 16'd0;
                cfg_vals[REG_GRACE]           = 16'd0;
            end
            SET_HIGH: begin
                cfg_vals[REG_CENTER_THROTTLE] = 16'hFFFF;
                cfg_vals[REG_CENTER_YAW]      = 16'h0FFF;
                cfg_vals[REG_CENTER_PITCH]    = 16'hFFFF;
                cfg_vals[REG_CENTER_ROLL]     = 16'h0FFF;
                cfg_vals[REG_GESTURE_THR]     = 16'hFFFF;
                cfg_vals[REG_GESTURE_HOLD]    = 16'hFFFF;
                cfg_vals[REG_DEBOUNCE]        = 16'hFFFF;
                cfg_vals[REG_GRACE]           = 16'hFFFF;
            end
            SET_DEFAULT: begin
                cfg_vals[REG_CENTER_THROTTLE] = {junk, CENTER_RST};
                cfg_vals[REG_CENTER_YAW]      = {4'd0, CENTER_RST};
                cfg_vals[REG_CENTER_PITCH]    = {4'd0, CENTER_RST};
                cfg_vals[REG_CENTER_ROLL]     = {4'd0, CENTER_RST};
                cfg_vals[REG_GESTURE_THR]     = {4'd0, GEST_THR_RST};
                cfg_vals[REG_GESTURE_HOLD]    = HOLD_MS_RST;
                cfg_vals[REG_DEBOUNCE]        = DEBOUNCE_RST;
                cfg_vals[REG_GRACE]           = GRACE_RST;
            end
            default: begin
                for (int i = REG_CENTER_THROTTLE; i <= REG_CENTER_ROLL; i++)
                    cfg_vals[i] = {4'($urandom),
                                   12'(($urandom_range(9, 0) == 0) ?
                                       $urandom_range(ADC_MAX, 0) :
                                       $urandom_range(2600, 1500))};
                cfg_vals[REG_GESTURE_THR]  = {4'($urandom), 12'($urandom_range(1300, 0))};
                cfg_vals[REG_GESTURE_HOLD] = ($urandom_range(7, 0) == 0) ?
                                             16'($urandom) : 16'($urandom_range(300, 0));
                cfg_vals[REG_DEBOUNCE]     = ($urandom_range(7, 0) == 0) ?
                                             16'($urandom) : 16'($urandom_range(80, 0));
                cfg_vals[REG_GRACE]        = ($urandom_range(7, 0) == 0) ?
                                             16'($urandom) : 16'($urandom_range(400, 0));
            end
        endcase
    endtask

    // Stick reading around a center: near the deadband, moderate or far out.
    function automatic int stick_near(int c);
        int off;
        int v;
        case ($urandom_range(2, 0))
            0: off = $urandom_range(60, 0);
            1: off = $urandom_range(400, 0);
            default: off = $urandom_range(2200, 0);
        endcase
        if ($urandom_range(1, 0) == 1) off = -off;
        v = c + off;
        if (v < 0) v = 0;
        if (v > ADC_MAX) v = ADC_MAX;
        return v;
    endfunction

    // Corner readings that pass the gesture test where the limits allow it.
    function automatic int corner_low(int c, int t);
        return (c - t > 0) ? $urandom_range(c - t - 1, 0) : 0;
    endfunction

    function automatic int corner_high(int c, int t);
        return (c + t < ADC_MAX) ? $urandom_range(ADC_MAX, c + t + 1) : ADC_MAX;
    endfunction

    // Build the next random sample for the given stimulus style.
    task automatic next_random_item(t_stim_mode mode);
        int th;
        th = sb.gest_th;
        case (mode)
            MODE_NOISE: begin
                s_now = $urandom;
                s_l = 1'($urandom);
                s_r = 1'($urandom);
                s_thr = $urandom_range(ADC_MAX, 0);
                s_yaw = $urandom_range(ADC_MAX, 0);
                s_pit = $urandom_range(ADC_MAX, 0);
                s_rol = $urandom_range(ADC_MAX, 0);
                l_hold = 0;
                r_hold = 0;
            end
            MODE_FLIGHT: begin
                s_now += ($urandom_range(9, 0) == 0) ? $urandom_range(1000, 0) :
                                                       $urandom_range(30, 0);
                // short presses on either stick, now and then both
                if (l_hold == 0 && $urandom_range(11, 0) == 0) l_hold = $urandom_range(3, 1);
                if (r_hold == 0 && $urandom_range(15, 0) == 0) r_hold = $urandom_range(3, 1);
                s_l = (l_hold == 0);
                s_r = (r_hold == 0);
                if (l_hold > 0) l_hold--;
                if (r_hold > 0) r_hold--;
                s_thr = ($urandom_range(7, 0) == 0) ? $urandom_range(ADC_MAX, 0) :
                                                      stick_near(sb.ctr_thr);
                s_yaw = stick_near(sb.ctr_yaw);
                s_pit = stick_near(sb.ctr_pit);
                s_rol = stick_near(sb.ctr_rol);
            end
            default: begin
                l_hold = 0;
                r_hold = 0;
                s_r = 1'b1;
                if (sb.armed) begin
                    // disarm first: release, then press past the debounce time
                    if (!s_l) begin
                        s_l = 1'b1;
                        s_now += $urandom_range(10, 0);
                    end else begin
                        s_l = 1'b0;
                        s_now += sb.deb_ms + $urandom_range(20, 1);
                    end
                end else begin
                    s_l = 1'b1;
                    s_now += $urandom_range(sb.hold_ms / 4 + 5, 0);
                end
                s_thr = corner_low(sb.ctr_thr, th);
                s_yaw = corner_high(sb.ctr_yaw, th);
                s_pit = corner_low(sb.ctr_pit, th);
                s_rol = corner_low(sb.ctr_rol, th);
                // break the gesture now and then
                if ($urandom_range(19, 0) == 0) begin
                    case ($urandom_range(3, 0))
                        0: s_thr = stick_near(sb.ctr_thr);
                        1: s_yaw = stick_near(sb.ctr_yaw);
                        2: s_pit = stick_near(sb.ctr_pit);
                        default: s_rol = stick_near(sb.ctr_rol);
                    endcase
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_stim_mode mode;
        t_set_kind  kind;
        int         items;
        int         seg;
        int         pick;

        sb = new();
        cycle_count = 0;
        stall_mode = 0;
        stall_left = 0;
        l_hold = 0;
        r_hold = 0;
        burst_left = 1;
        s_l = 1'b1;
        s_r = 1'b1;

        // Drive every input to a known value before the first edge.
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_now_ms <= '0;
        i_left_click <= 1'b1;
        i_right_click <= 1'b1;
        i_raw_throttle <= '0;
        i_raw_yaw <= '0;
        i_raw_pitch <= '0;
        i_raw_roll <= '0;
        i_out_stall <= 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset register values.
        send_item(32'd0, 1, 1, 2048, 2048, 2048, 2048);
        // gesture at time 0: stamp reads as not holding, restart next sample
        send_item(32'd0, 1, 1, 100, 4000, 100, 100);
        send_item(32'd10, 1, 1, 100, 4000, 100, 100);
        // press inside the debounce interval: no toggle
        send_item(32'd100, 0, 1, 0, 4095, 0, 0);
        // hold time reached: calibrate flag rises
        send_item(32'd3010, 0, 1, 100, 4000, 100, 100);
        // deadband edges on each side
        send_item(32'd3020, 1, 1, 2048 + 39, 2048 - 39, 2048 + 40, 2048 - 40);
        // arm; throttle held at zero through the grace window
        send_item(32'd3030, 0, 1, 4095, 0, 4095, 4095);
        send_item(32'd3040, 1, 1, 4095, 2048, 2048, 2048);
        send_item(32'd3330, 1, 1, 4095, 2048, 2048, 2048);
        // throttle floor boundary
        send_item(32'd3340, 1, 1, 2048 - 120, 2048, 2048, 2048);
        send_item(32'd3350, 1, 1, 2048 - 121, 2048, 2048, 2048);
        // disarm by the right stick
        send_item(32'd3360, 1, 0, 3000, 1000, 3000, 1000);
        send_item(32'd3361, 1, 1, 3000, 1000, 3000, 1000);
        // grace window spanning the time wrap ends early
        send_item(32'hFFFF_FF00, 0, 1, 4095, 4095, 0, 4095);
        send_item(32'hFFFF_FF10, 1, 1, 4095, 4095, 0, 4095);
        send_item(32'hFFFF_FFFF, 1, 0, 2048, 2048, 2048, 2048);
        send_item(32'hFFFF_FFFF, 1, 1, 2048, 2048, 2048, 2048);
        // grace end landing exactly on zero: no window at all
        send_item(32'hFFFF_FED4, 0, 1, 4095, 2048, 2048, 2048);
        send_item(32'hFFFF_FED5, 1, 1, 4095, 2048, 2048, 2048);
        send_item(32'h0000_0005, 1, 0, 4095, 2048, 2048, 2048);
        send_item($urandom, 1, 1, $urandom_range(ADC_MAX, 0), $urandom_range(ADC_MAX, 0),
                  $urandom_range(ADC_MAX, 0), $urandom_range(ADC_MAX, 0));

        // Random part: one register setting per phase, extremes first,
        // reset values last.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            if (p == 0) kind = SET_LOW;
            else if (p == 1) kind = SET_HIGH;
            else if (p == NUM_PHASES - 1) kind = SET_DEFAULT;
            else kind = SET_RANDOM;
            pick_settings(kind);
            load_settings();
            // start some phases just short of the time wrap
            s_now = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FFFF - $urandom_range(2000, 0) :
                                                  $urandom;
            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                pick = $urandom_range(9, 0);
                mode = (pick == 0) ? MODE_NOISE : (pick < 5) ? MODE_GESTURE : MODE_FLIGHT;
                seg = $urandom_range(60, 10);
                repeat (seg) begin
                    next_random_item(mode);
                    drive_sample();
                    items++;
                end
            end
        end

        // Drain the pipe and report.
        wait_idle();
        if (sb.errors == 0)
            $display("stick_command_arm_encoder_core test passed");
        else
            $display("stick_command_arm_encoder_core test failed");
        $finish;
    end

endmodule

FILE: stick_command_arm_encoder_core.f
+incdir+hw/rtl
hw/rtl/sce_pkg.sv
hw/rtl/sce_axis.sv
hw/rtl/sce_throttle.sv
hw/rtl/sce_ctl.sv
hw/rtl/stick_command_arm_encoder_core.sv
sim/tb.sv
